### rtl/jsu_pkg.sv
// Shared types, constants and helper functions for the JSON string unescaper.
// Used by jsu_front, jsu_queue, jsu_back and json_string_unescape_utf8.
package jsu_pkg;

	localparam int COUNT_BITS_DEF  = 24;
	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int CFG_W           = 24;

	localparam logic [CFG_W-1:0] MAX_OUT_RESET = 24'd65536;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_U     = 8'h75;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam logic [15:0] SURR_HI_LO = 16'hD800;
	localparam logic [15:0] SURR_HI_HI = 16'hDBFF;
	localparam logic [15:0] SURR_LO_LO = 16'hDC00;
	localparam logic [15:0] SURR_LO_HI = 16'hDFFF;
	localparam logic [20:0] SUPP_BASE  = 21'h10000;

	localparam logic [20:0] UTF8_MAX1 = 21'h7F;
	localparam logic [20:0] UTF8_MAX2 = 21'h7FF;
	localparam logic [20:0] UTF8_MAX3 = 21'hFFFF;
	localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
	localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
	localparam logic [7:0]  UTF8_LEAD4 = 8'hF0;
	localparam logic [7:0]  UTF8_CONT  = 8'h80;

	typedef enum logic [3:0] {
		ST_DATA       = 4'd0,
		ST_DONE       = 4'd1,
		ST_NO_QUOTE   = 4'd2,
		ST_UNTERM     = 4'd3,
		ST_RAW_CTRL   = 4'd4,
		ST_TRUNC_ESC  = 4'd5,
		ST_UNK_ESC    = 4'd6,
		ST_TRUNC_UNI  = 4'd7,
		ST_BAD_HEX    = 4'd8,
		ST_UNP_HIGH   = 4'd9,
		ST_BAD_LOW    = 4'd10,
		ST_UNP_LOW    = 4'd11,
		ST_TOO_LARGE  = 4'd12
	} jsu_status_t;

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_BODY = 3'd1,
		PH_ESC  = 3'd2,
		PH_HEX  = 3'd3,
		PH_SBS  = 3'd4,
		PH_SU   = 3'd5,
		PH_LHEX = 3'd6
	} jsu_phase_t;

	// Results of one input beat: up to four data bytes, then an optional status.
	typedef struct packed {
		logic [3:0][7:0] data;
		logic [2:0]      n_data;
		logic            has_st;
		jsu_status_t     st;
	} jsu_job_t;

	typedef struct packed {
		logic [2:0]      n;
		logic [3:0][7:0] bytes;
	} jsu_utf8_t;

	// {valid, value}
	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [4:0] r;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end else begin
			r = 5'd0;
		end
		return r;
	endfunction

	// {valid, decoded byte} for the single-character escapes
	function automatic logic [8:0] esc_map(input logic [7:0] c);
		logic [8:0] r;
		case (c)
			8'h22:   r = {1'b1, 8'h22};
			8'h5C:   r = {1'b1, 8'h5C};
			8'h2F:   r = {1'b1, 8'h2F};
			8'h62:   r = {1'b1, 8'h08};
			8'h66:   r = {1'b1, 8'h0C};
			8'h6E:   r = {1'b1, 8'h0A};
			8'h72:   r = {1'b1, 8'h0D};
			8'h74:   r = {1'b1, 8'h09};
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	function automatic jsu_utf8_t utf8_enc(input logic [20:0] cp);
		jsu_utf8_t r;
		r.bytes = '0;
		if (cp <= UTF8_MAX1) begin
			r.n = 3'd1;
			r.bytes[0] = cp[7:0];
		end else if (cp <= UTF8_MAX2) begin
			r.n = 3'd2;
			r.bytes[0] = UTF8_LEAD2 | {3'b000, cp[10:6]};
			r.bytes[1] = UTF8_CONT | {2'b00, cp[5:0]};
		end else if (cp <= UTF8_MAX3) begin
			r.n = 3'd3;
			r.bytes[0] = UTF8_LEAD3 | {4'b0000, cp[15:12]};
			r.bytes[1] = UTF8_CONT | {2'b00, cp[11:6]};
			r.bytes[2] = UTF8_CONT | {2'b00, cp[5:0]};
		end else begin
			r.n = 3'd4;
			r.bytes[0] = UTF8_LEAD4 | {5'b00000, cp[20:18]};
			r.bytes[1] = UTF8_CONT | {2'b00, cp[17:12]};
			r.bytes[2] = UTF8_CONT | {2'b00, cp[11:6]};
			r.bytes[3] = UTF8_CONT | {2'b00, cp[5:0]};
		end
		return r;
	endfunction

endpackage

### rtl/jsu_front.sv
// Front end: takes text bytes, runs the escape state machine and budget check,
// and builds one job per beat. Depends on jsu_pkg.
module jsu_front #(
	parameter int COUNT_BITS = jsu_pkg::COUNT_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [jsu_pkg::CFG_W-1:0] cfg_wdata,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [7:0]                in_byte,
	input  logic                      in_last,
	input  logic                      q_full,
	output logic                      push,
	output jsu_pkg::jsu_job_t         job
);

	localparam int BW   = COUNT_BITS + 1;
	localparam int CMPW = 34;
	localparam logic [jsu_pkg::CFG_W-1:0] CFG_MASK = (COUNT_BITS >= jsu_pkg::CFG_W) ? '1 :
		jsu_pkg::CFG_W'((64'd1 << COUNT_BITS) - 64'd1);

	jsu_pkg::jsu_phase_t phase_q, phase_d;
	logic [15:0]               hex_q, hex_d;
	logic [1:0]                cnt_q, cnt_d;
	logic [9:0]                high_q, high_d;
	logic [BW-1:0]             bytes_q, bytes_d;
	logic [jsu_pkg::CFG_W-1:0] max_q;

	logic                      accept;
	logic [4:0]                hx;
	logic                      hv_ok;
	logic [15:0]               acc_new;
	logic                      cnt_end;
	logic                      is_high, is_low;
	logic [8:0]                esc;
	logic [20:0]               cp;
	jsu_pkg::jsu_utf8_t        enc;
	logic [2:0]                emit_n;
	logic [BW:0]               sum;
	logic [BW-1:0]             bytes_sum;
	logic                      too_large;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign push     = accept && (job.n_data != 3'd0 || job.has_st);

	// Datapath shared by both state machine blocks
	assign hx      = jsu_pkg::hex_val(in_byte);
	assign hv_ok   = hx[4];
	assign acc_new = {hex_q[11:0], hx[3:0]};
	assign cnt_end = (cnt_q == 2'd3);
	assign is_high = (acc_new >= jsu_pkg::SURR_HI_LO) && (acc_new <= jsu_pkg::SURR_HI_HI);
	assign is_low  = (acc_new >= jsu_pkg::SURR_LO_LO) && (acc_new <= jsu_pkg::SURR_LO_HI);
	assign esc     = jsu_pkg::esc_map(in_byte);

	always_comb begin
		case (phase_q)
			jsu_pkg::PH_ESC:  cp = {13'd0, esc[7:0]};
			jsu_pkg::PH_LHEX: cp = jsu_pkg::SUPP_BASE + {1'b0, high_q, acc_new[9:0]};
			default:          cp = {5'd0, acc_new};
		endcase
	end

	assign enc       = jsu_pkg::utf8_enc(cp);
	assign emit_n    = (phase_q == jsu_pkg::PH_BODY) ? 3'd1 : enc.n;
	assign sum       = {1'b0, bytes_q} + (BW+1)'(emit_n);
	assign bytes_sum = sum[BW] ? '1 : sum[BW-1:0];
	assign too_large = CMPW'(bytes_sum) > CMPW'(max_q);

	// Next phase
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			jsu_pkg::PH_IDLE: begin
				phase_d = (in_byte == jsu_pkg::CH_QUOTE && !in_last) ?
					jsu_pkg::PH_BODY : jsu_pkg::PH_IDLE;
			end
			jsu_pkg::PH_BODY: begin
				if (in_byte == jsu_pkg::CH_QUOTE || in_byte < jsu_pkg::CH_SPACE || in_last) begin
					phase_d = jsu_pkg::PH_IDLE;
				end else if (in_byte == jsu_pkg::CH_BSL) begin
					phase_d = jsu_pkg::PH_ESC;
				end else begin
					phase_d = jsu_pkg::PH_BODY;
				end
			end
			jsu_pkg::PH_ESC: begin
				if (esc[8]) begin
					phase_d = (too_large || in_last) ? jsu_pkg::PH_IDLE : jsu_pkg::PH_BODY;
				end else if (in_byte == jsu_pkg::CH_U && !in_last) begin
					phase_d = jsu_pkg::PH_HEX;
				end else begin
					phase_d = jsu_pkg::PH_IDLE;
				end
			end
			jsu_pkg::PH_HEX: begin
				if (!hv_ok || in_last) begin
					phase_d = jsu_pkg::PH_IDLE;
				end else if (!cnt_end) begin
					phase_d = jsu_pkg::PH_HEX;
				end else if (is_high) begin
					phase_d = jsu_pkg::PH_SBS;
				end else if (is_low || too_large) begin
					phase_d = jsu_pkg::PH_IDLE;
				end else begin
					phase_d = jsu_pkg::PH_BODY;
				end
			end
			jsu_pkg::PH_SBS: begin
				phase_d = (in_byte == jsu_pkg::CH_BSL && !in_last) ?
					jsu_pkg::PH_SU : jsu_pkg::PH_IDLE;
			end
			jsu_pkg::PH_SU: begin
				phase_d = (in_byte == jsu_pkg::CH_U && !in_last) ?
					jsu_pkg::PH_LHEX : jsu_pkg::PH_IDLE;
			end
			jsu_pkg::PH_LHEX: begin
				if (!hv_ok || in_last) begin
					phase_d = jsu_pkg::PH_IDLE;
				end else if (!cnt_end) begin
					phase_d = jsu_pkg::PH_LHEX;
				end else if (!is_low || too_large) begin
					phase_d = jsu_pkg::PH_IDLE;
				end else begin
					phase_d = jsu_pkg::PH_BODY;
				end
			end
			default: phase_d = jsu_pkg::PH_IDLE;
		endcase
	end

	// Job and datapath register updates
	always_comb begin
		job        = '0;
		job.st     = jsu_pkg::ST_DATA;
		hex_d      = hex_q;
		cnt_d      = cnt_q;
		high_d     = high_q;
		bytes_d    = bytes_q;
		unique case (phase_q)
			jsu_pkg::PH_IDLE: begin
				if (in_byte != jsu_pkg::CH_QUOTE) begin
					job.has_st = 1'b1;
					job.st     = jsu_pkg::ST_NO_QUOTE;
				end else begin
					bytes_d = '0;
					if (in_last) begin
						job.has_st = 1'b1;
						job.st     = jsu_pkg::ST_UNTERM;
					end
				end
			end
			jsu_pkg::PH_BODY: begin
				if (in_byte == jsu_pkg::CH_QUOTE) begin
					job.has_st = 1'b1;
					job.st     = jsu_pkg::ST_DONE;
				end else if (in_byte < jsu_pkg::CH_SPACE) begin
					job.has_st = 1'b1;
					job.st     = jsu_pkg::ST_RAW_CTRL;
				end else if (in_byte == jsu_pkg::CH_BSL) begin
					if (in_last) begin
						job.has_st = 1'b1;
						job.st     = jsu_pkg::ST_TRUNC_ESC;
					end
				end else begin
					job.n_data  = 3'd1;
					job.data[0] = in_byte;
					bytes_d     = bytes_sum;
					if (in_last) begin
						job.has_st = 1'b1;
						job.st     = jsu_pkg::ST_UNTERM;
					end
				end
			end
			jsu_pkg::PH_ESC: begin
				if (esc[8]) begin
					job.n_data = enc.n;
					job.data   = enc.bytes;
					bytes_d    = bytes_sum;
					hex_d      = '0;
					cnt_d      = '0;
					high_d     = '0;
					if (too_large) begin
						job.has_st = 1'b1;
						job.st     = jsu_pkg::ST_TOO_LARGE;
					end else if (in_last) begin
						job.has_st = 1'b1;
						job.st     = jsu_pkg::ST_UNTERM;
					end
				end else if (in_byte == jsu_pkg::CH_U) begin
					hex_d = '0;
					cnt_d = '0;
					if (in_last) begin
						job.has_st = 1'b1;
						job.st     = jsu_pkg::ST_TRUNC_UNI;
					end
				end else begin
					job.has_st = 1'b1;
					job.st     = jsu_pkg::ST_UNK_ESC;
				end
			end
			jsu_pkg::PH_HEX: begin
				if (!hv_ok) begin
					job.has_st = 1'b1;
					job.st     = jsu_pkg::ST_BAD_HEX;
				end else if (!cnt_end) begin
					hex_d = acc_new;
					cnt_d = cnt_q + 2'd1;
					if (in_last) begin
						job.has_st = 1'b1;
						job.st     = jsu_pkg::ST_TRUNC_UNI;
					end
				end else if (is_high) begin
					high_d = acc_new[9:0];
					hex_d  = '0;
					cnt_d  = '0;
					if (in_last) begin
						job.has_st = 1'b1;
						job.st     = jsu_pkg::ST_UNP_HIGH;
					end
				end else if (is_low) begin
					job.has_st = 1'b1;
					job.st     = jsu_pkg::ST_UNP_LOW;
				end else begin
					job.n_data = enc.n;
					job.data   = enc.bytes;
					bytes_d    = bytes_sum;
					hex_d      = '0;
					cnt_d      = '0;
					high_d     = '0;
					if (too_large) begin
						job.has_st = 1'b1;
						job.st     = jsu_pkg::ST_TOO_LARGE;
					end else if (in_last) begin
						job.has_st = 1'b1;
						job.st     = jsu_pkg::ST_UNTERM;
					end
				end
			end
			jsu_pkg::PH_SBS: begin
				if (in_byte != jsu_pkg::CH_BSL || in_last) begin
					job.has_st = 1'b1;
					job.st     = jsu_pkg::ST_UNP_HIGH;
				end
			end
			jsu_pkg::PH_SU: begin
				if (in_byte != jsu_pkg::CH_U || in_last) begin
					job.has_st = 1'b1;
					job.st     = jsu_pkg::ST_UNP_HIGH;
				end else begin
					hex_d = '0;
					cnt_d = '0;
				end
			end
			jsu_pkg::PH_LHEX: begin
				if (!hv_ok) begin
					job.has_st = 1'b1;
					job.st     = jsu_pkg::ST_BAD_LOW;
				end else if (!cnt_end) begin
					hex_d = acc_new;
					cnt_d = cnt_q + 2'd1;
					if (in_last) begin
						job.has_st = 1'b1;
						job.st     = jsu_pkg::ST_UNP_HIGH;
					end
				end else if (!is_low) begin
					job.has_st = 1'b1;
					job.st     = jsu_pkg::ST_BAD_LOW;
				end else begin
					job.n_data = enc.n;
					job.data   = enc.bytes;
					bytes_d    = bytes_sum;
					hex_d      = '0;
					cnt_d      = '0;
					high_d     = '0;
					if (too_large) begin
						job.has_st = 1'b1;
						job.st     = jsu_pkg::ST_TOO_LARGE;
					end else if (in_last) begin
						job.has_st = 1'b1;
						job.st     = jsu_pkg::ST_UNTERM;
					end
				end
			end
			default: ;
		endcase
		// dropping back to idle clears the escape state
		if (phase_d == jsu_pkg::PH_IDLE) begin
			hex_d  = '0;
			cnt_d  = '0;
			high_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= jsu_pkg::PH_IDLE;
			hex_q   <= '0;
			cnt_q   <= '0;
			high_q  <= '0;
			bytes_q <= '0;
			max_q   <= jsu_pkg::MAX_OUT_RESET;
		end else begin
			if (cfg_we) begin
				max_q <= cfg_wdata & CFG_MASK;
			end
			if (accept) begin
				phase_q <= phase_d;
				hex_q   <= hex_d;
				cnt_q   <= cnt_d;
				high_q  <= high_d;
				bytes_q <= bytes_d;
			end
		end
	end

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == jsu_pkg::PH_IDLE |-> (cnt_q == 2'd0 && high_q == 10'd0 && hex_q == 16'd0))
		else $error("escape state not cleared in idle");

endmodule

### rtl/jsu_queue.sv
// Short job queue between the front and back ends, held in flip-flops.
// Depends on jsu_pkg for the job type.
module jsu_queue #(
	parameter int DEPTH = jsu_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  jsu_pkg::jsu_job_t wr_job,
	input  logic              pop,
	output jsu_pkg::jsu_job_t rd_job,
	output logic              not_empty,
	output logic              full
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	jsu_pkg::jsu_job_t slot_q [DEPTH];
	logic [PW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]     count_q;

	assign rd_job    = slot_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign full      = (count_q == CW'(DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("job pushed into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("job popped from an empty queue");

endmodule

### rtl/jsu_back.sv
// Back end: unpacks each queued job into result beats, one per cycle while
// out_stall is low, through an output register. Depends on jsu_pkg.
module jsu_back (
	input  logic              clk,
	input  logic              arst_n,
	input  jsu_pkg::jsu_job_t head_job,
	input  logic              head_valid,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        out_byte,
	output logic              has_byte,
	output logic [3:0]        status,
	output logic              run_last
);

	jsu_pkg::jsu_job_t cur_q;
	logic              cur_valid_q;
	logic [2:0]        idx_q;
	logic              out_valid_q;
	logic [7:0]        out_byte_q;
	logic              has_byte_q;
	jsu_pkg::jsu_status_t status_q;
	logic              run_last_q;

	logic [2:0]        total;
	logic              res_last;
	logic              is_data;
	logic              take;
	logic              cur_free;

	assign total    = cur_q.n_data + {2'b00, cur_q.has_st};
	assign res_last = (idx_q + 3'd1) == total;
	assign is_data  = idx_q < cur_q.n_data;
	assign take     = cur_valid_q && (!out_valid_q || !out_stall);
	assign cur_free = !cur_valid_q || (take && res_last);
	assign pop      = cur_free && head_valid;

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign has_byte  = has_byte_q;
	assign status    = status_q;
	assign run_last  = run_last_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head_job;
		end
		if (take) begin
			out_byte_q <= is_data ? cur_q.data[idx_q[1:0]] : 8'd0;
			has_byte_q <= is_data;
			status_q   <= is_data ? jsu_pkg::ST_DATA : cur_q.st;
			run_last_q <= res_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cur_free) begin
				cur_valid_q <= head_valid;
				idx_q       <= '0;
			end else if (take) begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	a_status_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !has_byte_q) |-> run_last_q)
		else $error("status beat not marked as last of its run");

	a_data_code: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && has_byte_q) |-> (status_q == jsu_pkg::ST_DATA))
		else $error("data beat carries a non-data status");

endmodule

### rtl/json_string_unescape_utf8.sv
// Top level of the JSON string unescaper with UTF-8 output.
// Instantiates jsu_front, jsu_queue and jsu_back; depends on jsu_pkg.
//
// Feed the bytes of one JSON string literal, opening quote first, one byte per
// input beat, with in_last high on the final byte of the text. Plain bytes pass
// through (bytes of 0x80 and above unchanged), simple escapes become one byte,
// and \u escapes, surrogate pairs included, become 1 to 4 UTF-8 bytes. Each
// string closes with one status beat (has_byte low): done, or an error code, after
// which the block waits for the next opening quote; discard any bytes sent before
// an error. run_last marks the final result beat caused by an input byte. The
// decoded byte budget in max_out_bytes (cfg_wdata, written with cfg_we while idle)
// is checked only after an escape. Rate: the front end takes one byte per cycle
// while the job queue (QUEUE_DEPTH entries) has room; the back end delivers one
// result beat per cycle while out_stall is low. A byte expands into up to five
// result beats, for a four-byte character ending a string.
module json_string_unescape_utf8 #(
	parameter int COUNT_BITS  = jsu_pkg::COUNT_BITS_DEF,
	parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// configuration
	input  logic                      cfg_we,
	input  logic [jsu_pkg::CFG_W-1:0] cfg_wdata,
	// text input
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [7:0]                in_byte,
	input  logic                      in_last,
	// decoded output
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [7:0]                out_byte,
	output logic                      has_byte,
	output logic [3:0]                status,
	output logic                      run_last
);

	jsu_pkg::jsu_job_t push_job;
	jsu_pkg::jsu_job_t head_job;
	logic              push;
	logic              pop;
	logic              q_full;
	logic              q_not_empty;

	// Classify each byte and build its job; stall only on a full queue
	jsu_front #(
		.COUNT_BITS (COUNT_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_byte   (in_byte),
		.in_last   (in_last),
		.q_full    (q_full),
		.push      (push),
		.job       (push_job)
	);

	// Decouple input beats from multi-beat output runs
	jsu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_job    (push_job),
		.pop       (pop),
		.rd_job    (head_job),
		.not_empty (q_not_empty),
		.full      (q_full)
	);

	// Drain jobs one result beat at a time
	jsu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_job   (head_job),
		.head_valid (q_not_empty),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.has_byte   (has_byte),
		.status     (status),
		.run_last   (run_last)
	);

endmodule
